>>> hdl/ich_pkg.sv
// ich_pkg: shared types and constants for the incremental convex hull core
// no dependencies
package ich_pkg;
	localparam int MaxVertices = 32;
	localparam int CoordBits = 16;
	localparam int IdxBits = $clog2(MaxVertices);
	localparam int CntBits = $clog2(MaxVertices + 1);
	localparam int ProdBits = 2 * (CoordBits + 1);
	localparam int CrossBits = ProdBits + 1;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic op;
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
		logic [4:0] vertex_index;
	} cmd_t;

	typedef struct packed {
		logic [5:0] hull_count;
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic index_valid;
		logic point_inside;
		logic overflow;
	} rsp_t;

	// request to the shared cross product unit
	typedef struct packed {
		logic go;
		logic signed [CoordBits-1:0] ax;
		logic signed [CoordBits-1:0] ay;
		logic signed [CoordBits-1:0] bx;
		logic signed [CoordBits-1:0] by;
		logic signed [CoordBits-1:0] px;
		logic signed [CoordBits-1:0] py;
	} xreq_t;

	typedef struct packed {
		logic done;
		logic pos;
		logic neg;
	} xrsp_t;
endpackage

>>> hdl/ich_cross.sv
// ich_cross: shared turn unit, one multiplier used twice, sign of cross product
// depends on ich_pkg
module ich_cross (
	input logic clk,
	input logic arst_n,
	input ich_pkg::xreq_t req,
	output ich_pkg::xrsp_t rsp
);
	typedef enum logic [3:0] {
		X_IDLE = 4'b0001,
		X_MUL1 = 4'b0010,
		X_MUL2 = 4'b0100,
		X_DONE = 4'b1000
	} xstate_t;

	xstate_t state_q;
	logic signed [ich_pkg::CoordBits:0] d1_q, d2_q, d3_q, d4_q;
	logic signed [ich_pkg::ProdBits-1:0] prod_q;
	logic signed [ich_pkg::CrossBits-1:0] acc_q;
	logic signed [ich_pkg::CoordBits:0] ma, mb;
	logic signed [ich_pkg::ProdBits-1:0] mp;

	always_comb begin
		ma = (state_q == X_MUL1) ? d1_q : d3_q;
		mb = (state_q == X_MUL1) ? d2_q : d4_q;
		mp = ma * mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= X_IDLE;
		end else begin
			unique case (state_q)
				X_IDLE: if (req.go) state_q <= X_MUL1;
				X_MUL1: state_q <= X_MUL2;
				X_MUL2: state_q <= X_DONE;
				X_DONE: state_q <= X_IDLE;
				default: state_q <= X_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == X_IDLE && req.go) begin
			d1_q <= (ich_pkg::CoordBits+1)'(req.bx) - (ich_pkg::CoordBits+1)'(req.ax);
			d2_q <= (ich_pkg::CoordBits+1)'(req.py) - (ich_pkg::CoordBits+1)'(req.ay);
			d3_q <= (ich_pkg::CoordBits+1)'(req.by) - (ich_pkg::CoordBits+1)'(req.ay);
			d4_q <= (ich_pkg::CoordBits+1)'(req.px) - (ich_pkg::CoordBits+1)'(req.ax);
		end
		if (state_q == X_MUL1) prod_q <= mp;
		if (state_q == X_MUL2)
			acc_q <= ich_pkg::CrossBits'(prod_q) - ich_pkg::CrossBits'(mp);
	end

	assign rsp.done = (state_q == X_DONE);
	assign rsp.neg = acc_q[ich_pkg::CrossBits-1];
	assign rsp.pos = !acc_q[ich_pkg::CrossBits-1] && (acc_q != '0);
endmodule

>>> hdl/incremental_convex_hull_core.sv
// incremental_convex_hull_core: top level, sequencer and vertex ring memory
// depends on ich_pkg and ich_cross
//
// usage: drive a cmd_t on cmd and raise start; the transfer happens at a rising
// edge with start high and busy low, and busy stays high until the result is out.
// op add inserts a point into a counter-clockwise hull ring, op read returns the
// vertex at vertex_index counted from the base vertex.
// exactly one rsp_t appears on rsp with done high for one cycle; the receiver
// cannot stall, and busy falls the cycle after done.
// steps from the accepting edge to the done cycle:
//   read: address the ring and capture the vertex
//   one of the first three adds: a write, with a turn test first for the third
//   later add, n vertices: each edge goes to the shared cross product unit
//   (read a, read b, two products on the one multiplier); an inside point ends
//   there, a dropped point after the tangent scan, an insertion after the tangent
//   scan, a rebuild into a scratch bank and a copy back to the ring
// the single read port of the ring memory and the one multiplier limit the speed
// reset clears the vertex count and the point counter; the ring memory itself
// holds whatever was last written and needs no clearing pass, since only
// entries below the vertex count are ever used
module incremental_convex_hull_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ich_pkg::cmd_t cmd,
	output logic busy,
	output logic done,
	output ich_pkg::rsp_t rsp
);
	localparam int IB = ich_pkg::IdxBits;
	localparam int CB = ich_pkg::CntBits;
	localparam int NV = ich_pkg::MaxVertices;
	localparam int CW = ich_pkg::CoordBits;

	typedef enum logic [16:0] {
		S_IDLE = 17'b00000000000000001,
		S_RD   = 17'b00000000000000010, // read op: address the ring
		S_RDW  = 17'b00000000000000100, // read op: capture vertex
		S_EA   = 17'b00000000000001000, // edge: address vertex i
		S_EB   = 17'b00000000000010000, // edge: capture a, address vertex i+1
		S_EC   = 17'b00000000000100000, // edge: capture b, launch turn unit
		S_EW   = 17'b00000000001000000, // edge: wait on turn unit
		S_SW1  = 17'b00000000010000000, // seeding: move second vertex to slot 2
		S_SW2  = 17'b00000000100000000, // seeding: write the new point
		S_TAN  = 17'b00000001000000000, // scan edge signs for tangents
		S_CHK  = 17'b00000010000000000, // tangent and capacity check
		S_BR   = 17'b00000100000000000, // rebuild: address vertex j
		S_BW   = 17'b00001000000000000, // rebuild: keep vertex j
		S_BP   = 17'b00010000000000000, // rebuild: insert the point after left
		S_CR   = 17'b00100000000000000, // copy: address scratch
		S_CW   = 17'b01000000000000000, // copy: write ring
		S_OUT  = 17'b10000000000000000
	} state_t;

	state_t state_q;
	ich_pkg::cmd_t cmd_q;
	ich_pkg::rsp_t rsp_q;
	logic [CB-1:0] n_q;
	logic [1:0] seen_q;
	logic [CB-1:0] i_q;
	logic [CB-1:0] m_q;
	logic [IB-1:0] j_q;
	logic [IB-1:0] left_q, right_q;
	logic have_l_q, have_r_q, outside_q, swap_q;
	logic [NV-1:0] pos_q; // edge i strictly left turn
	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic done_q;
	logic accept;

	// vertex ring and scratch bank
	logic [2*CW-1:0] ring_mem [NV];
	logic [2*CW-1:0] scr_mem [NV];
	logic [2*CW-1:0] ring_rd_q, scr_rd_q;
	logic ring_we, scr_we;
	logic [IB-1:0] ring_ra, ring_wa, scr_ra, scr_wa;
	logic [2*CW-1:0] ring_wd, scr_wd;

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[ring_wa] <= ring_wd;
		ring_rd_q <= ring_mem[ring_ra];
		if (scr_we) scr_mem[scr_wa] <= scr_wd;
		scr_rd_q <= scr_mem[scr_ra];
	end

	ich_pkg::xreq_t xreq;
	ich_pkg::xrsp_t xrsp;
	ich_cross u_cross (.clk(clk), .arst_n(arst_n), .req(xreq), .rsp(xrsp));

	// ring index helpers
	logic [IB-1:0] i_idx, i_nxt, j_nxt, tan_i, tan_p;
	logic i_last;
	logic [CB-1:0] k_cnt, newn, relj;
	logic gone_j, gone0;

	assign busy = (state_q != S_IDLE) || done_q;
	assign accept = start && !busy;

	assign i_idx = i_q[IB-1:0];
	assign i_last = (i_q + CB'(1) == n_q);
	assign i_nxt = i_last ? '0 : IB'(i_q + CB'(1));
	assign j_nxt = (CB'(j_q) + CB'(1) == n_q) ? '0 : j_q + IB'(1);
	// scan position t maps to index t mod n, its previous edge is t - 1
	assign tan_i = (i_q == n_q) ? '0 : i_q[IB-1:0];
	assign tan_p = IB'(i_q - CB'(1));

	always_comb begin
		// removed vertices strictly between left and right, going forward
		if (right_q > left_q) k_cnt = CB'(right_q) - CB'(left_q) - CB'(1);
		else k_cnt = CB'(right_q) + n_q - CB'(left_q) - CB'(1);
		newn = n_q - k_cnt + CB'(1);
		// distance of j after left, modulo n
		if (j_q >= left_q) relj = CB'(j_q) - CB'(left_q);
		else relj = CB'(j_q) + n_q - CB'(left_q);
		gone_j = (relj != '0) && (relj <= k_cnt);
		gone0 = (left_q != '0) && ((n_q - CB'(left_q)) <= k_cnt);
	end

	always_comb begin
		xreq = '0;
		xreq.ax = ax_q;
		xreq.ay = ay_q;
		xreq.bx = ring_rd_q[2*CW-1:CW];
		xreq.by = ring_rd_q[CW-1:0];
		xreq.px = cmd_q.x_coord;
		xreq.py = cmd_q.y_coord;
		xreq.go = (state_q == S_EC);
		ring_we = 1'b0;
		ring_wa = i_idx;
		ring_wd = {cmd_q.x_coord, cmd_q.y_coord};
		ring_ra = i_idx;
		scr_we = 1'b0;
		scr_wa = m_q[IB-1:0];
		scr_wd = ring_rd_q;
		scr_ra = i_idx;
		unique case (state_q)
			S_RD: ring_ra = cmd_q.vertex_index[IB-1:0];
			S_EA: ring_ra = i_idx;
			S_EB: ring_ra = i_nxt;
			S_SW1: begin
				ring_we = 1'b1;
				ring_wa = IB'(2);
				ring_wd = {bx_q, by_q};
			end
			S_SW2: begin
				ring_we = 1'b1;
				ring_wa = swap_q ? IB'(1) : n_q[IB-1:0];
			end
			S_BR: ring_ra = j_q;
			S_BW: scr_we = !gone_j;
			S_BP: begin
				scr_we = 1'b1;
				scr_wd = {cmd_q.x_coord, cmd_q.y_coord};
			end
			S_CW: begin
				ring_we = 1'b1;
				ring_wd = scr_rd_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			seen_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					if (cmd.op == ich_pkg::OP_READ) state_q <= S_RD;
					else if (seen_q != 2'd3) begin
						// third point needs a turn test against the first two
						if (seen_q == 2'd2 && n_q == CB'(2)) state_q <= S_EA;
						else state_q <= S_SW2;
					end else if (n_q < CB'(3)) state_q <= S_OUT;
					else state_q <= S_EA;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: state_q <= S_OUT;
				S_EA: state_q <= S_EB;
				S_EB: state_q <= S_EC;
				S_EC: state_q <= S_EW;
				S_EW: if (xrsp.done) begin
					// collinear third counts as clockwise
					if (seen_q != 2'd3) state_q <= xrsp.pos ? S_SW2 : S_SW1;
					else if (i_last) state_q <= (outside_q || xrsp.neg) ? S_TAN : S_OUT;
					else state_q <= S_EA;
				end
				S_SW1: state_q <= S_SW2;
				S_SW2: begin
					if (n_q < CB'(NV)) n_q <= n_q + CB'(1);
					seen_q <= seen_q + 2'd1;
					state_q <= S_OUT;
				end
				S_TAN: if (i_q == n_q) state_q <= S_CHK;
				S_CHK: begin
					if (!have_l_q || !have_r_q || newn > CB'(NV)) state_q <= S_OUT;
					else state_q <= S_BR;
				end
				S_BR: state_q <= S_BW;
				S_BW: begin
					if (j_q == left_q) state_q <= S_BP;
					else if (i_last) state_q <= S_CR;
					else state_q <= S_BR;
				end
				S_BP: state_q <= i_last ? S_CR : S_BR;
				S_CR: state_q <= S_CW;
				S_CW: begin
					if (i_q + CB'(1) == m_q) begin
						n_q <= m_q;
						state_q <= S_OUT;
					end else state_q <= S_CR;
				end
				S_OUT: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				cmd_q <= cmd;
				rsp_q <= '0;
				i_q <= '0;
				outside_q <= 1'b0;
				swap_q <= 1'b0;
			end
			S_RDW: begin
				if (CB'(cmd_q.vertex_index) < n_q) begin
					rsp_q.vertex_x <= ring_rd_q[2*CW-1:CW];
					rsp_q.vertex_y <= ring_rd_q[CW-1:0];
					rsp_q.index_valid <= 1'b1;
				end
			end
			S_EB: {ax_q, ay_q} <= ring_rd_q;
			S_EC: {bx_q, by_q} <= ring_rd_q;
			S_EW: if (xrsp.done) begin
				if (seen_q != 2'd3) swap_q <= !xrsp.pos;
				else begin
					pos_q[i_idx] <= xrsp.pos;
					if (xrsp.neg) outside_q <= 1'b1;
					if (i_last) begin
						i_q <= CB'(1);
						have_l_q <= 1'b0;
						have_r_q <= 1'b0;
						// on or inside every edge: dropped
						if (!outside_q && !xrsp.neg) rsp_q.point_inside <= 1'b1;
					end else i_q <= i_q + CB'(1);
				end
			end
			S_TAN: begin
				// scan order 1 .. n-1 then 0, last candidate wins
				if (!pos_q[tan_p] && pos_q[tan_i]) begin
					right_q <= tan_i;
					have_r_q <= 1'b1;
				end else if (pos_q[tan_p] && !pos_q[tan_i]) begin
					left_q <= tan_i;
					have_l_q <= 1'b1;
				end
				if (i_q != n_q) i_q <= i_q + CB'(1);
			end
			S_CHK: begin
				if (have_l_q && have_r_q && newn > CB'(NV)) rsp_q.overflow <= 1'b1;
				// base removed: right tangent becomes the new base
				j_q <= gone0 ? right_q : '0;
				i_q <= '0;
				m_q <= '0;
			end
			S_BW: begin
				if (!gone_j) m_q <= m_q + CB'(1);
				if (j_q != left_q) begin
					if (i_last) i_q <= '0;
					else begin
						i_q <= i_q + CB'(1);
						j_q <= j_nxt;
					end
				end
			end
			S_BP: begin
				m_q <= m_q + CB'(1);
				if (i_last) i_q <= '0;
				else begin
					i_q <= i_q + CB'(1);
					j_q <= j_nxt;
				end
			end
			S_CW: i_q <= i_q + CB'(1);
			S_OUT: rsp_q.hull_count <= 6'(n_q);
			default: ;
		endcase
	end

	assign done = done_q;
	assign rsp = rsp_q;

	property p_done_once;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_done_once: assert property (p_done_once) else $error("done held");

	property p_count_max;
		@(posedge clk) disable iff (!arst_n) n_q <= CB'(NV);
	endproperty
	a_count_max: assert property (p_count_max) else $error("count past capacity");

	property p_busy_done;
		@(posedge clk) disable iff (!arst_n) done |-> busy;
	endproperty
	a_busy_done: assert property (p_busy_done) else $error("done while idle");

	property p_accept_busy;
		@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy;
	endproperty
	a_accept_busy: assert property (p_accept_busy) else $error("busy missing after transfer");
endmodule

>>> tb/incremental_convex_hull_core_tb.sv
// incremental_convex_hull_core_tb: self-checking bench for the convex hull core
// depends on ich_pkg and incremental_convex_hull_core; holds its own hull predictor
`timescale 1ns / 100ps

module incremental_convex_hull_core_tb;
	logic clk;
	logic arst_n;
	logic start;
	ich_pkg::cmd_t cmd;
	logic busy;
	logic done;
	ich_pkg::rsp_t rsp;

	incremental_convex_hull_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.rsp(rsp)
	);

	// predicted hull state
	logic signed [15:0] ring_x [ich_pkg::MaxVertices];
	logic signed [15:0] ring_y [ich_pkg::MaxVertices];
	int ring_count;
	int adds_seen;

	ich_pkg::rsp_t expected_rsp [$];
	int error_count;
	int rsp_count;
	int add_count;
	int read_count;
	int inside_count;
	int overflow_count;
	longint cycle_count;

	localparam longint CycleLimit = 3000000;

	initial begin
		clk = 1'b0;
	end

	always #2 clk = ~clk;

	// sign of the cross product (b - a) x (p - a)
	function automatic int turn_sign(longint ax, longint ay, longint bx, longint by,
		longint px, longint py);
		longint v;
		v = (bx - ax) * (py - ay) - (by - ay) * (px - ax);
		if (v < 0) return -1;
		if (v > 0) return 1;
		return 0;
	endfunction

	function automatic int edge_sign(int i, longint px, longint py);
		int j;
		j = (i + 1) % ring_count;
		return turn_sign(ring_x[i], ring_y[i], ring_x[j], ring_y[j], px, py);
	endfunction

	// update predicted hull for one add, fill the flags of the result
	task automatic hull_insert(logic signed [15:0] px, logic signed [15:0] py,
		inout ich_pkg::rsp_t r);
		int n;
		int left;
		int right;
		int l;
		int k;
		int m;
		int strt;
		int j;
		int p;
		bit outside;
		bit ep;
		bit en;
		bit gone [ich_pkg::MaxVertices];
		logic signed [15:0] tx [ich_pkg::MaxVertices];
		logic signed [15:0] ty [ich_pkg::MaxVertices];
		n = ring_count;
		// the first three points seed the hull, collinear third goes in the middle
		if (adds_seen < 3) begin
			if (adds_seen == 2 && n == 2 &&
				turn_sign(ring_x[0], ring_y[0], ring_x[1], ring_y[1], px, py) != 1) begin
				ring_x[2] = ring_x[1];
				ring_y[2] = ring_y[1];
				ring_x[1] = px;
				ring_y[1] = py;
			end else if (n < ich_pkg::MaxVertices) begin
				ring_x[n] = px;
				ring_y[n] = py;
			end
			if (n < ich_pkg::MaxVertices) ring_count = n + 1;
			adds_seen++;
			return;
		end
		if (n < 3) return;
		outside = 1'b0;
		for (int i = 0; i < n; i++)
			if (edge_sign(i, px, py) < 0) outside = 1'b1;
		if (!outside) begin
			r.point_inside = 1'b1;
			return;
		end
		// tangents: last candidate in scan order 1..n-1 then 0 wins
		left = -1;
		right = -1;
		for (int t = 1; t <= n; t++) begin
			j = t % n;
			p = (j + n - 1) % n;
			ep = edge_sign(p, px, py) == 1;
			en = edge_sign(j, px, py) == 1;
			if (!ep && en) right = j;
			else if (ep && !en) left = j;
		end
		if (left < 0 || right < 0) return;
		l = left;
		k = (right + n - l - 1) % n;
		if (n - k + 1 > ich_pkg::MaxVertices) begin
			r.overflow = 1'b1;
			return;
		end
		for (int i = 0; i < ich_pkg::MaxVertices; i++) gone[i] = 1'b0;
		for (int t = 0; t < k; t++) gone[(l + 1 + t) % n] = 1'b1;
		// base removed: right tangent becomes the new base
		strt = gone[0] ? right : 0;
		m = 0;
		for (int t = 0; t < n; t++) begin
			j = (strt + t) % n;
			if (!gone[j] && m < ich_pkg::MaxVertices) begin
				tx[m] = ring_x[j];
				ty[m] = ring_y[j];
				m++;
			end
			if (j == l && m < ich_pkg::MaxVertices) begin
				tx[m] = px;
				ty[m] = py;
				m++;
			end
		end
		for (int i = 0; i < m; i++) begin
			ring_x[i] = tx[i];
			ring_y[i] = ty[i];
		end
		ring_count = m;
	endtask

	task automatic predict_hull(ich_pkg::cmd_t c);
		ich_pkg::rsp_t r;
		r = '0;
		if (c.op == ich_pkg::OP_READ) begin
			read_count++;
			if (int'(c.vertex_index) < ring_count) begin
				r.vertex_x = ring_x[c.vertex_index];
				r.vertex_y = ring_y[c.vertex_index];
				r.index_valid = 1'b1;
			end
		end else begin
			add_count++;
			hull_insert(c.x_coord, c.y_coord, r);
			if (r.point_inside) inside_count++;
			if (r.overflow) overflow_count++;
		end
		r.hull_count = ring_count[5:0];
		expected_rsp.push_back(r);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
			got, want);
		error_count++;
	endtask

	// one transfer: random gap, wait for busy low, then start for one edge
	task automatic send_cmd(ich_pkg::cmd_t c, bit no_gap = 1'b0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		repeat (gap) @(negedge clk);
		while (busy) @(negedge clk);
		cmd <= c;
		start <= 1'b1;
		@(posedge clk);
		predict_hull(c);
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic send_add(int x, int y);
		ich_pkg::cmd_t c;
		c = '0;
		c.op = ich_pkg::OP_ADD;
		c.x_coord = x[15:0];
		c.y_coord = y[15:0];
		send_cmd(c);
	endtask

	task automatic send_read(int idx);
		ich_pkg::cmd_t c;
		c = '0;
		c.op = ich_pkg::OP_READ;
		c.vertex_index = idx[4:0];
		c.x_coord = 16'($urandom());
		c.y_coord = 16'($urandom());
		send_cmd(c);
	endtask

	task automatic wait_drained();
		while (expected_rsp.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		ich_pkg::rsp_t e;
		if (arst_n && done) begin
			rsp_count++;
			if (expected_rsp.size() == 0) begin
				$display("unexpected result at cycle %0d", cycle_count);
				error_count++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.hull_count !== e.hull_count)
					report_mismatch("hull_count", rsp.hull_count, e.hull_count);
				if (rsp.vertex_x !== e.vertex_x)
					report_mismatch("vertex_x", rsp.vertex_x, e.vertex_x);
				if (rsp.vertex_y !== e.vertex_y)
					report_mismatch("vertex_y", rsp.vertex_y, e.vertex_y);
				if (rsp.index_valid !== e.index_valid)
					report_mismatch("index_valid", rsp.index_valid, e.index_valid);
				if (rsp.point_inside !== e.point_inside)
					report_mismatch("point_inside", rsp.point_inside, e.point_inside);
				if (rsp.overflow !== e.overflow)
					report_mismatch("overflow", rsp.overflow, e.overflow);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// directed: seeding with collinear third, extremes, inside, boundary, reads
	task automatic test_directed();
		send_read(0);
		send_add(-32768, -32768);
		send_read(0);
		send_read(1);
		send_add(32767, 32767);
		send_add(0, 0);
		for (int i = 0; i < 4; i++) send_read(i);
		send_add(32767, -32768);
		send_add(-32768, 32767);
		send_add(0, 0);
		send_add(32767, 0);
		send_add(-32768, -32768);
		send_add(-1, 32767);
		send_add(100, -32768);
		for (int i = 0; i < 6; i++) send_read(i);
		send_read(31);
	endtask

	// hull growth toward capacity: points at random angles on a circle of radius 30000
	task automatic test_capacity();
		int ang;
		for (int i = 0; i < 60; i++) begin
			ang = $urandom_range(0, 359);
			send_add($rtoi(30000.0 * $cos(ang * 3.14159265 / 180.0)),
				$rtoi(30000.0 * $sin(ang * 3.14159265 / 180.0)));
			if (i % 10 == 0) send_read($urandom_range(0, 31));
		end
		for (int i = 0; i < 32; i++) send_read(i);
	endtask

	// random mix; small and full-range coordinates
	task automatic test_random(int count);
		ich_pkg::cmd_t c;
		int sel;
		for (int i = 0; i < count; i++) begin
			c = '0;
			c.op = ($urandom_range(0, 3) == 0) ? ich_pkg::OP_READ : ich_pkg::OP_ADD;
			sel = $urandom_range(0, 3);
			c.x_coord = (sel == 0) ? 16'($signed($urandom_range(0, 40)) - 20) :
				16'($urandom());
			c.y_coord = (sel == 0) ? 16'($signed($urandom_range(0, 40)) - 20) :
				16'($urandom());
			c.vertex_index = 5'($urandom());
			send_cmd(c, $urandom_range(0, 3) == 0);
			if (i == count / 2) wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		error_count = 0;
		rsp_count = 0;
		add_count = 0;
		read_count = 0;
		inside_count = 0;
		overflow_count = 0;
		cycle_count = 0;
		ring_count = 0;
		adds_seen = 0;
		for (int i = 0; i < ich_pkg::MaxVertices; i++) begin
			ring_x[i] = '0;
			ring_y[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_capacity();
		test_random(1900);
		wait_drained();
		repeat (400) @(negedge clk);
		$display("covered %0d adds, %0d reads, %0d dropped inside, %0d overflow",
			add_count, read_count, inside_count, overflow_count);
		$display("%0d results checked, final hull size %0d", rsp_count, ring_count);
		if (error_count == 0 && expected_rsp.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
